/* rtl/ghs_pkg.sv */
// shared types, constants and helpers for the graham scan hull block
// no dependencies
package ghs_pkg;

    localparam int DEF_MAX_POINTS = 64;
    localparam int COORD_W        = 16;
    localparam int MIN_HULL       = 3;
    localparam int SCAN_FLOOR     = 2;
    localparam int OPER_W         = COORD_W + 3;
    localparam int PROD_W         = 2 * OPER_W;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

    // datapath command, one per cycle
    typedef enum logic [4:0] {
        DP_NOP,
        DP_RD_ZERO,
        DP_RD_I,
        DP_RD_I1,
        DP_RD_JM1,
        DP_AN_INIT,
        DP_AN_CMP,
        DP_SW_WR1,
        DP_SW_WR0,
        DP_SO_TMP,
        DP_EVAL_TURN_A,
        DP_EVAL_DIST,
        DP_EVAL_TURN_S,
        DP_SO_SHIFT,
        DP_SO_PLACE,
        DP_DD_INIT,
        DP_TMP_RD,
        DP_DD_FLUSH,
        DP_DD_MERGE,
        DP_DD_KEEP,
        DP_DEG_OUT,
        DP_SC_W0,
        DP_SC_W1,
        DP_SC_W2,
        DP_SC_POP,
        DP_SC_S0,
        DP_SC_PUSH,
        DP_EM_RD,
        DP_EM_LOAD
    } ghs_op_t;

    // datapath status back to the controller
    typedef struct packed {
        logic i_ge_n;
        logic i1_ge_n;
        logic i_ge_m;
        logic j_le1;
        logic n_lt2;
        logic m_lt3;
        logic sp_gt2;
        logic u_done;
        logic u_neg;
        logic u_zero;
        logic out_beat;
        logic out_last;
    } ghs_stat_t;

    function automatic logic signed [OPER_W-1:0] sext_oper(input logic signed [COORD_W-1:0] v);
        sext_oper = {{(OPER_W-COORD_W){v[COORD_W-1]}}, v};
    endfunction

endpackage

/* rtl/ghs_cross.sv */
// two-stage a*b +/- c*d unit, reports sign and zero of the result
// depends on ghs_pkg
module ghs_cross
    import ghs_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic                     mode_add,
    input  logic signed [OPER_W-1:0] a,
    input  logic signed [OPER_W-1:0] b,
    input  logic signed [OPER_W-1:0] c,
    input  logic signed [OPER_W-1:0] d,
    output logic                     done,
    output logic                     neg,
    output logic                     zero
);

    logic signed [PROD_W-1:0] ab_reg;
    logic signed [PROD_W-1:0] cd_reg;
    logic                     add_reg;
    logic                     v1_reg;
    logic                     done_reg;
    logic signed [PROD_W:0]   sum_reg;
    logic signed [PROD_W:0]   sum_next;

    // combine the registered products
    always_comb begin
        if (add_reg) begin
            sum_next = {ab_reg[PROD_W-1], ab_reg} + {cd_reg[PROD_W-1], cd_reg};
        end else begin
            sum_next = {ab_reg[PROD_W-1], ab_reg} - {cd_reg[PROD_W-1], cd_reg};
        end
    end

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            v1_reg   <= start;
            done_reg <= v1_reg;
        end
    end

    // product and sum stages
    always_ff @(posedge aclk) begin
        if (start) begin
            ab_reg  <= a * b;
            cd_reg  <= c * d;
            add_reg <= mode_add;
        end
        if (v1_reg) begin
            sum_reg <= sum_next;
        end
    end

    assign done = done_reg;
    assign neg  = sum_reg[PROD_W];
    assign zero = (sum_reg == '0);

endmodule

/* rtl/ghs_datapath.sv */
// point store, hull stack, index counters and output register
// depends on ghs_pkg and ghs_cross
module ghs_datapath
    import ghs_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  ghs_op_t                   op,
    input  logic                      in_beat,
    input  logic signed [COORD_W-1:0] s_point_x,
    input  logic signed [COORD_W-1:0] s_point_y,
    input  logic                      m_ready,
    output logic                      m_valid,
    output logic signed [COORD_W-1:0] m_hull_x,
    output logic signed [COORD_W-1:0] m_hull_y,
    output logic                      m_hull_valid,
    output logic                      m_overflow,
    output logic                      m_hull_last,
    output ghs_stat_t                 stat
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    point_t mem [MAX_POINTS];
    point_t stk [MAX_POINTS];

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] sp_reg, sp_next;
    logic          mv_reg, mv_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] m_reg, m_next;
    logic [AW-1:0] bidx_reg, bidx_next;
    point_t        best_reg, best_next;
    point_t        anchor_reg, anchor_next;
    point_t        tmp_reg, tmp_next;
    point_t        s0_reg, s0_next;
    point_t        s1_reg, s1_next;
    point_t        rd_reg;
    point_t        srd_reg;
    point_t        out_reg, out_next;
    logic          hv_reg, hv_next;
    logic          hl_reg, hl_next;

    logic          mem_we, mem_re, stk_we, stk_re;
    logic [AW-1:0] mem_wa, mem_ra, stk_wa, stk_ra;
    point_t        mem_wd, stk_wd;

    logic [CW-1:0] i_inc, j_dec, sp_dec, sp_dec3, m_inc;
    logic          better, out_beat;

    logic          u_start, u_dist, u_side;
    point_t        pp, pq, pr;
    logic signed [OPER_W-1:0] px, py, qx, qy, rx, ry;
    logic signed [OPER_W-1:0] ua, ub, uc, ud;
    logic          u_done, u_neg, u_zero;

    assign i_inc    = i_reg + CW'(1);
    assign j_dec    = j_reg - CW'(1);
    assign sp_dec   = sp_reg - CW'(1);
    assign sp_dec3  = sp_reg - CW'(3);
    assign m_inc    = m_reg + CW'(1);
    assign out_beat = mv_reg & m_ready;
    assign better   = (rd_reg.y < best_reg.y) ||
                      ((rd_reg.y == best_reg.y) && (rd_reg.x < best_reg.x));

    // operand selection for the cross product unit
    always_comb begin
        if (u_side) begin
            pp = s0_reg;
            pq = s1_reg;
            pr = tmp_reg;
        end else begin
            pp = anchor_reg;
            pq = tmp_reg;
            pr = rd_reg;
        end
        px = sext_oper(pp.x);
        py = sext_oper(pp.y);
        qx = sext_oper(pq.x);
        qy = sext_oper(pq.y);
        rx = sext_oper(pr.x);
        ry = sext_oper(pr.y);
        if (u_dist) begin
            // |q-p|^2 - |r-p|^2 as a difference of squares
            ua = qx - rx;
            ub = qx + rx - (px <<< 1);
            uc = qy - ry;
            ud = qy + ry - (py <<< 1);
        end else begin
            ua = qy - py;
            ub = rx - qx;
            uc = qx - px;
            ud = ry - qy;
        end
    end

    ghs_cross u_cross (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (u_start),
        .mode_add (u_dist),
        .a        (ua),
        .b        (ub),
        .c        (uc),
        .d        (ud),
        .done     (u_done),
        .neg      (u_neg),
        .zero     (u_zero)
    );

    // command decode
    always_comb begin
        cnt_next    = cnt_reg;
        ovf_next    = ovf_reg;
        sp_next     = sp_reg;
        mv_next     = mv_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        m_next      = m_reg;
        bidx_next   = bidx_reg;
        best_next   = best_reg;
        anchor_next = anchor_reg;
        tmp_next    = tmp_reg;
        s0_next     = s0_reg;
        s1_next     = s1_reg;
        out_next    = out_reg;
        hv_next     = hv_reg;
        hl_next     = hl_reg;
        mem_we      = 1'b0;
        mem_wa      = '0;
        mem_wd      = tmp_reg;
        mem_re      = 1'b0;
        mem_ra      = '0;
        stk_we      = 1'b0;
        stk_wa      = '0;
        stk_wd      = tmp_reg;
        stk_re      = 1'b0;
        stk_ra      = '0;
        u_start     = 1'b0;
        u_dist      = 1'b0;
        u_side      = 1'b0;

        // point load
        if (in_beat) begin
            if (cnt_reg < CW'(MAX_POINTS)) begin
                mem_we   = 1'b1;
                mem_wa   = cnt_reg[AW-1:0];
                mem_wd   = '{x: s_point_x, y: s_point_y};
                cnt_next = cnt_reg + CW'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end

        // result beat taken, end of set on the last one
        if (out_beat) begin
            mv_next = 1'b0;
            if (hl_reg) begin
                cnt_next = '0;
                ovf_next = 1'b0;
                sp_next  = '0;
            end
        end

        unique case (op)
            DP_NOP: begin
            end
            DP_RD_ZERO: begin
                mem_re = 1'b1;
            end
            DP_RD_I: begin
                mem_re = 1'b1;
                mem_ra = i_reg[AW-1:0];
            end
            DP_RD_I1: begin
                mem_re = 1'b1;
                mem_ra = i_inc[AW-1:0];
            end
            DP_RD_JM1: begin
                mem_re = 1'b1;
                mem_ra = j_dec[AW-1:0];
            end
            DP_AN_INIT: begin
                best_next = rd_reg;
                bidx_next = '0;
                i_next    = CW'(1);
            end
            DP_AN_CMP: begin
                if (better) begin
                    best_next = rd_reg;
                    bidx_next = i_reg[AW-1:0];
                end
                i_next = i_inc;
            end
            DP_SW_WR1: begin
                mem_we = 1'b1;
                mem_wa = bidx_reg;
                mem_wd = rd_reg;
            end
            DP_SW_WR0: begin
                mem_we      = 1'b1;
                mem_wd      = best_reg;
                anchor_next = best_reg;
                i_next      = CW'(2);
            end
            DP_SO_TMP: begin
                tmp_next = rd_reg;
                j_next   = i_reg;
            end
            DP_EVAL_TURN_A: begin
                u_start = 1'b1;
            end
            DP_EVAL_DIST: begin
                u_start = 1'b1;
                u_dist  = 1'b1;
            end
            DP_EVAL_TURN_S: begin
                u_start = 1'b1;
                u_side  = 1'b1;
            end
            DP_SO_SHIFT: begin
                mem_we = 1'b1;
                mem_wa = j_reg[AW-1:0];
                mem_wd = rd_reg;
                j_next = j_dec;
            end
            DP_SO_PLACE: begin
                mem_we = 1'b1;
                mem_wa = j_reg[AW-1:0];
                i_next = i_inc;
            end
            DP_DD_INIT: begin
                m_next = CW'(1);
                i_next = CW'(1);
                mem_re = 1'b1;
                mem_ra = AW'(1);
            end
            DP_TMP_RD: begin
                tmp_next = rd_reg;
            end
            DP_DD_FLUSH: begin
                mem_we = 1'b1;
                mem_wa = m_reg[AW-1:0];
                m_next = m_inc;
            end
            DP_DD_MERGE: begin
                tmp_next = rd_reg;
                i_next   = i_inc;
            end
            DP_DD_KEEP: begin
                mem_we   = 1'b1;
                mem_wa   = m_reg[AW-1:0];
                m_next   = m_inc;
                i_next   = i_inc;
                tmp_next = rd_reg;
            end
            DP_DEG_OUT: begin
                out_next = '0;
                hv_next  = 1'b0;
                hl_next  = 1'b1;
                mv_next  = 1'b1;
            end
            DP_SC_W0: begin
                stk_we = 1'b1;
                stk_wd = rd_reg;
                mem_re = 1'b1;
                mem_ra = AW'(1);
            end
            DP_SC_W1: begin
                stk_we  = 1'b1;
                stk_wa  = AW'(1);
                stk_wd  = rd_reg;
                s0_next = rd_reg;
                mem_re  = 1'b1;
                mem_ra  = AW'(2);
            end
            DP_SC_W2: begin
                stk_we  = 1'b1;
                stk_wa  = AW'(2);
                stk_wd  = rd_reg;
                s1_next = rd_reg;
                sp_next = CW'(3);
                i_next  = CW'(3);
            end
            DP_SC_POP: begin
                sp_next = sp_dec;
                s1_next = s0_reg;
                stk_re  = 1'b1;
                stk_ra  = sp_dec3[AW-1:0];
            end
            DP_SC_S0: begin
                s0_next = srd_reg;
            end
            DP_SC_PUSH: begin
                if (sp_reg < CW'(MAX_POINTS)) begin
                    stk_we  = 1'b1;
                    stk_wa  = sp_reg[AW-1:0];
                    sp_next = sp_reg + CW'(1);
                    s0_next = s1_reg;
                    s1_next = tmp_reg;
                end
                i_next = i_inc;
            end
            DP_EM_RD: begin
                stk_re = 1'b1;
                stk_ra = sp_dec[AW-1:0];
            end
            DP_EM_LOAD: begin
                out_next = srd_reg;
                hv_next  = 1'b1;
                hl_next  = (sp_reg == CW'(1));
                sp_next  = sp_dec;
                mv_next  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // point store and hull stack, registered reads
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_reg <= mem[mem_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk[stk_wa] <= stk_wd;
        end
        if (stk_re) begin
            srd_reg <= stk[stk_ra];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            sp_reg  <= '0;
            mv_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
            sp_reg  <= sp_next;
            mv_reg  <= mv_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        m_reg      <= m_next;
        bidx_reg   <= bidx_next;
        best_reg   <= best_next;
        anchor_reg <= anchor_next;
        tmp_reg    <= tmp_next;
        s0_reg     <= s0_next;
        s1_reg     <= s1_next;
        out_reg    <= out_next;
        hv_reg     <= hv_next;
        hl_reg     <= hl_next;
    end

    // status to the controller
    always_comb begin
        stat.i_ge_n   = (i_reg >= cnt_reg);
        stat.i1_ge_n  = (i_inc >= cnt_reg);
        stat.i_ge_m   = (i_reg >= m_reg);
        stat.j_le1    = (j_reg <= CW'(1));
        stat.n_lt2    = (cnt_reg < CW'(2));
        stat.m_lt3    = (m_reg < CW'(MIN_HULL));
        stat.sp_gt2   = (sp_reg > CW'(SCAN_FLOOR));
        stat.u_done   = u_done;
        stat.u_neg    = u_neg;
        stat.u_zero   = u_zero;
        stat.out_beat = out_beat;
        stat.out_last = hl_reg;
    end

    assign m_valid      = mv_reg;
    assign m_hull_x     = out_reg.x;
    assign m_hull_y     = out_reg.y;
    assign m_hull_valid = hv_reg;
    assign m_overflow   = ovf_reg;
    assign m_hull_last  = hl_reg;

endmodule

/* rtl/ghs_ctrl.sv */
// sequencer for load, anchor search, angle sort, collinear pruning,
// stack scan and emission; depends on ghs_pkg
module ghs_ctrl
    import ghs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_point_last,
    input  ghs_stat_t stat,
    output logic      s_ready,
    output ghs_op_t   op
);

    typedef enum logic [34:0] {
        ST_IDLE     = 35'd1 << 0,
        ST_AN_RD0   = 35'd1 << 1,
        ST_AN_INIT  = 35'd1 << 2,
        ST_AN_RD    = 35'd1 << 3,
        ST_AN_CMP   = 35'd1 << 4,
        ST_SW_RD0   = 35'd1 << 5,
        ST_SW_WR1   = 35'd1 << 6,
        ST_SW_WR0   = 35'd1 << 7,
        ST_SO_NEXT  = 35'd1 << 8,
        ST_SO_TMP   = 35'd1 << 9,
        ST_SO_CHK   = 35'd1 << 10,
        ST_SO_TURN  = 35'd1 << 11,
        ST_SO_TW    = 35'd1 << 12,
        ST_SO_DIST  = 35'd1 << 13,
        ST_SO_DW    = 35'd1 << 14,
        ST_SO_SHIFT = 35'd1 << 15,
        ST_SO_PLACE = 35'd1 << 16,
        ST_DD_INIT  = 35'd1 << 17,
        ST_DD_LOAD  = 35'd1 << 18,
        ST_DD_CHK   = 35'd1 << 19,
        ST_DD_TURN  = 35'd1 << 20,
        ST_DD_TW    = 35'd1 << 21,
        ST_DG_CHK   = 35'd1 << 22,
        ST_SC_W0    = 35'd1 << 23,
        ST_SC_W1    = 35'd1 << 24,
        ST_SC_W2    = 35'd1 << 25,
        ST_SC_NEXT  = 35'd1 << 26,
        ST_SC_TMP   = 35'd1 << 27,
        ST_SC_CHK   = 35'd1 << 28,
        ST_SC_TW    = 35'd1 << 29,
        ST_SC_POP   = 35'd1 << 30,
        ST_SC_PUSH  = 35'd1 << 31,
        ST_EM_RD    = 35'd1 << 32,
        ST_EM_LOAD  = 35'd1 << 33,
        ST_OUT_HOLD = 35'd1 << 34
    } state_t;

    state_t state_reg, state_next;

    // next state and datapath command
    always_comb begin
        state_next = state_reg;
        op         = DP_NOP;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && s_point_last) begin
                    state_next = ST_AN_RD0;
                end
            end
            ST_AN_RD0: begin
                op         = DP_RD_ZERO;
                state_next = ST_AN_INIT;
            end
            ST_AN_INIT: begin
                op         = DP_AN_INIT;
                state_next = ST_AN_RD;
            end
            ST_AN_RD: begin
                if (stat.i_ge_n) begin
                    state_next = ST_SW_RD0;
                end else begin
                    op         = DP_RD_I;
                    state_next = ST_AN_CMP;
                end
            end
            ST_AN_CMP: begin
                op         = DP_AN_CMP;
                state_next = ST_AN_RD;
            end
            ST_SW_RD0: begin
                op         = DP_RD_ZERO;
                state_next = ST_SW_WR1;
            end
            ST_SW_WR1: begin
                op         = DP_SW_WR1;
                state_next = ST_SW_WR0;
            end
            ST_SW_WR0: begin
                op         = DP_SW_WR0;
                state_next = ST_SO_NEXT;
            end
            // insertion sort by angle about the anchor
            ST_SO_NEXT: begin
                if (stat.i_ge_n) begin
                    state_next = ST_DD_INIT;
                end else begin
                    op         = DP_RD_I;
                    state_next = ST_SO_TMP;
                end
            end
            ST_SO_TMP: begin
                op         = DP_SO_TMP;
                state_next = ST_SO_CHK;
            end
            ST_SO_CHK: begin
                if (stat.j_le1) begin
                    state_next = ST_SO_PLACE;
                end else begin
                    op         = DP_RD_JM1;
                    state_next = ST_SO_TURN;
                end
            end
            ST_SO_TURN: begin
                op         = DP_EVAL_TURN_A;
                state_next = ST_SO_TW;
            end
            ST_SO_TW: begin
                if (stat.u_done) begin
                    if (stat.u_zero) begin
                        state_next = ST_SO_DIST;
                    end else if (stat.u_neg) begin
                        state_next = ST_SO_SHIFT;
                    end else begin
                        state_next = ST_SO_PLACE;
                    end
                end
            end
            ST_SO_DIST: begin
                op         = DP_EVAL_DIST;
                state_next = ST_SO_DW;
            end
            ST_SO_DW: begin
                if (stat.u_done) begin
                    state_next = stat.u_neg ? ST_SO_SHIFT : ST_SO_PLACE;
                end
            end
            ST_SO_SHIFT: begin
                op         = DP_SO_SHIFT;
                state_next = ST_SO_CHK;
            end
            ST_SO_PLACE: begin
                op         = DP_SO_PLACE;
                state_next = ST_SO_NEXT;
            end
            // keep only the farthest of points collinear with the anchor
            ST_DD_INIT: begin
                op         = DP_DD_INIT;
                state_next = stat.n_lt2 ? ST_DG_CHK : ST_DD_LOAD;
            end
            ST_DD_LOAD: begin
                op         = DP_TMP_RD;
                state_next = ST_DD_CHK;
            end
            ST_DD_CHK: begin
                if (stat.i1_ge_n) begin
                    op         = DP_DD_FLUSH;
                    state_next = ST_DG_CHK;
                end else begin
                    op         = DP_RD_I1;
                    state_next = ST_DD_TURN;
                end
            end
            ST_DD_TURN: begin
                op         = DP_EVAL_TURN_A;
                state_next = ST_DD_TW;
            end
            ST_DD_TW: begin
                if (stat.u_done) begin
                    op         = stat.u_zero ? DP_DD_MERGE : DP_DD_KEEP;
                    state_next = ST_DD_CHK;
                end
            end
            ST_DG_CHK: begin
                if (stat.m_lt3) begin
                    op         = DP_DEG_OUT;
                    state_next = ST_OUT_HOLD;
                end else begin
                    op         = DP_RD_ZERO;
                    state_next = ST_SC_W0;
                end
            end
            // stack scan
            ST_SC_W0: begin
                op         = DP_SC_W0;
                state_next = ST_SC_W1;
            end
            ST_SC_W1: begin
                op         = DP_SC_W1;
                state_next = ST_SC_W2;
            end
            ST_SC_W2: begin
                op         = DP_SC_W2;
                state_next = ST_SC_NEXT;
            end
            ST_SC_NEXT: begin
                if (stat.i_ge_m) begin
                    state_next = ST_EM_RD;
                end else begin
                    op         = DP_RD_I;
                    state_next = ST_SC_TMP;
                end
            end
            ST_SC_TMP: begin
                op         = DP_TMP_RD;
                state_next = ST_SC_CHK;
            end
            ST_SC_CHK: begin
                if (stat.sp_gt2) begin
                    op         = DP_EVAL_TURN_S;
                    state_next = ST_SC_TW;
                end else begin
                    state_next = ST_SC_PUSH;
                end
            end
            ST_SC_TW: begin
                if (stat.u_done) begin
                    if (stat.u_neg) begin
                        state_next = ST_SC_PUSH;
                    end else begin
                        op         = DP_SC_POP;
                        state_next = ST_SC_POP;
                    end
                end
            end
            ST_SC_POP: begin
                op         = DP_SC_S0;
                state_next = ST_SC_CHK;
            end
            ST_SC_PUSH: begin
                op         = DP_SC_PUSH;
                state_next = ST_SC_NEXT;
            end
            // emit from stack top down to the anchor
            ST_EM_RD: begin
                op         = DP_EM_RD;
                state_next = ST_EM_LOAD;
            end
            ST_EM_LOAD: begin
                op         = DP_EM_LOAD;
                state_next = ST_OUT_HOLD;
            end
            ST_OUT_HOLD: begin
                if (stat.out_beat) begin
                    state_next = stat.out_last ? ST_IDLE : ST_EM_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/convex_hull_graham_scan.sv */
// channel   ports                                        direction
// input     s_valid s_ready s_point_x s_point_y s_point_last  in (one point per beat)
// result    m_valid m_ready m_hull_x m_hull_y m_hull_valid
//           m_overflow m_hull_last                         out (one hull vertex per beat)
//
// a point is stored in the cycle its beat is taken; a beat without last keeps the input open.
// after the last point the hull runs anchor search, insertion sort by angle with a
// distance compare when a turn test is zero (up to n*n/2 compares), collinear pruning
// and the stack scan with its pops; these steps share the two-stage cross product
// unit and the point store.
// a result beat is held until m_ready takes it; no point is taken until the last one goes.
// reset is synchronous and active low; no clearing pass.
// top level of the graham scan hull block; depends on ghs_pkg, ghs_ctrl, ghs_datapath
module convex_hull_graham_scan
    import ghs_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [COORD_W-1:0] s_point_x,
    input  logic signed [COORD_W-1:0] s_point_y,
    input  logic                      s_point_last,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [COORD_W-1:0] m_hull_x,
    output logic signed [COORD_W-1:0] m_hull_y,
    output logic                      m_hull_valid,
    output logic                      m_overflow,
    output logic                      m_hull_last
);

    ghs_op_t   op;
    ghs_stat_t stat;
    logic      in_beat;

    assign in_beat = s_valid & s_ready;

    ghs_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_point_last (s_point_last),
        .stat         (stat),
        .s_ready      (s_ready),
        .op           (op)
    );

    ghs_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .op           (op),
        .in_beat      (in_beat),
        .s_point_x    (s_point_x),
        .s_point_y    (s_point_y),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_hull_x     (m_hull_x),
        .m_hull_y     (m_hull_y),
        .m_hull_valid (m_hull_valid),
        .m_overflow   (m_overflow),
        .m_hull_last  (m_hull_last),
        .stat         (stat)
    );

endmodule

/* rtl/ghs_checker.sv */
// port-level checks for the graham scan hull block
// bound to convex_hull_graham_scan below; no package dependency
module ghs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [15:0] s_point_x,
    input logic [15:0] s_point_y,
    input logic        s_point_last,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_hull_x,
    input logic [15:0] m_hull_y,
    input logic        m_hull_valid,
    input logic        m_overflow,
    input logic        m_hull_last
);

    // input is closed while a result is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input open while a result is pending");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_hull_x) && $stable(m_hull_y)
            && $stable(m_hull_last) && $stable(m_hull_valid) && $stable(m_overflow)))
        else $error("result beat changed under stall");

    // a degenerate set gives exactly one beat
    a_deg_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_hull_valid) |-> m_hull_last)
        else $error("degenerate result not marked last");

    // the block reopens right after the final beat of a set
    a_reopen: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_hull_last) |=> s_ready)
        else $error("input not reopened after final beat");

    // a point without last keeps the input open
    a_load_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_point_last) |=> (s_ready && !m_valid))
        else $error("input closed mid set");

endmodule

bind convex_hull_graham_scan ghs_checker u_ghs_checker (.*);
